### design/lmcs_pkg.sv
// lmcs_pkg: shared types, constants and the letter decoder for the
// letter multiset cover selector. No dependencies.
`timescale 1ns / 1ps

package lmcs_pkg;

   // alphabet and character widths
   localparam int ALPHABET    = 26;
   localparam int IDX_W       = 5;
   localparam int CHAR_W      = 8;
   localparam int COUNT_W     = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // fixed widths of the result fields
   localparam int OUT_NUM_W   = 10;
   localparam int OUT_LEN_W   = 8;

   // default sizing
   localparam int MAX_WORDS_DEF  = 1024;
   localparam int MAX_LENGTH_DEF = 255;

   // operation codes
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_WORD = 1'b1;

   // character bounds
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

   typedef logic [COUNT_W-1:0] count_type;
   typedef count_type count_vec_type [ALPHABET];

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } letter_type;

   // case-insensitive letter decode, hit low for non-letters
   function automatic letter_type letter_decode(input logic [CHAR_W-1:0] ch);
      letter_type   res;
      logic [CHAR_W-1:0] diff;
      res  = '0;
      diff = '0;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         diff    = ch - CHAR_UPPER_A;
         res.hit = 1'b1;
         res.idx = diff[IDX_W-1:0];
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         diff    = ch - CHAR_LOWER_A;
         res.hit = 1'b1;
         res.idx = diff[IDX_W-1:0];
      end
      return res;
   endfunction

endpackage

### design/letter_multiset_cover_select.sv
// letter_multiset_cover_select: key and word letter histograms, cover test
// and running shortest completing word. Depends on lmcs_pkg.
// A word-end beat shows its result in the cycle after acceptance. Throughput:
// one character beat per cycle while no result is stalled; the 26-lane cover
// compare feeds a result register that takes a new beat while the previous
// result leaves. Synchronous active-high reset clears counts and control state.
`timescale 1ns / 1ps

module letter_multiset_cover_select #(
   parameter int MAX_WORDS  = lmcs_pkg::MAX_WORDS_DEF,
   parameter int MAX_LENGTH = lmcs_pkg::MAX_LENGTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // character beats
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operation,
   input  logic [lmcs_pkg::CHAR_W-1:0]     req_char_code,
   input  logic                            req_last_of_word,
   input  logic                            req_last_of_list,
   // result beats
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lmcs_pkg::OUT_NUM_W-1:0]  rsp_word_number,
   output logic [lmcs_pkg::OUT_LEN_W-1:0]  rsp_word_length,
   output logic                            rsp_completes,
   output logic                            rsp_best_found,
   output logic [lmcs_pkg::OUT_NUM_W-1:0]  rsp_best_number,
   output logic [lmcs_pkg::OUT_LEN_W-1:0]  rsp_best_length,
   output logic                            rsp_list_done
);

   localparam int NUM_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int LEN_W = $clog2(MAX_LENGTH + 1);
   localparam logic [NUM_W-1:0] NUM_LAST = NUM_W'(MAX_WORDS - 1);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_LENGTH);

   // histogram and list state
   lmcs_pkg::count_vec_type key_ff, key_in;
   lmcs_pkg::count_vec_type word_ff, word_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] best_num_ff, best_num_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic             have_best_ff, have_best_in;
   logic             phase_ff, phase_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0] out_num_ff, out_num_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;
   logic             out_cover_ff, out_cover_in;
   logic             out_found_ff, out_found_in;
   logic [NUM_W-1:0] out_best_num_ff, out_best_num_in;
   logic [LEN_W-1:0] out_best_len_ff, out_best_len_in;
   logic             out_done_ff, out_done_in;
   logic             rsp_load;

   logic                 req_take;
   logic                 covers;
   lmcs_pkg::letter_type lt;

   // input beat handshake
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign lt        = lmcs_pkg::letter_decode(req_char_code);

   // per-beat update of histograms, word length and running best
   always_comb begin
      key_in          = key_ff;
      word_in         = word_ff;
      len_in          = len_ff;
      num_in          = num_ff;
      best_num_in     = best_num_ff;
      best_len_in     = best_len_ff;
      have_best_in    = have_best_ff;
      phase_in        = phase_ff;
      rsp_load        = 1'b0;
      covers          = 1'b1;
      out_num_in      = num_ff;
      out_len_in      = len_ff;
      out_cover_in    = 1'b0;
      out_found_in    = have_best_ff;
      out_best_num_in = best_num_ff;
      out_best_len_in = best_len_ff;
      out_done_in     = req_last_of_list;
      if (req_take) begin
         if (req_operation == lmcs_pkg::OP_KEY) begin
            // key after words opens a fresh key
            if (phase_ff) begin
               for (int i = 0; i < lmcs_pkg::ALPHABET; i++) begin
                  key_in[i]  = '0;
                  word_in[i] = '0;
               end
               len_in       = '0;
               num_in       = '0;
               best_num_in  = '0;
               best_len_in  = '0;
               have_best_in = 1'b0;
               phase_in     = 1'b0;
            end
            if (lt.hit && key_in[lt.idx] != lmcs_pkg::COUNT_MAX) begin
               key_in[lt.idx] = key_in[lt.idx] + 1'b1;
            end
         end else begin
            phase_in = 1'b1;
            if (lt.hit && word_in[lt.idx] != lmcs_pkg::COUNT_MAX) begin
               word_in[lt.idx] = word_in[lt.idx] + 1'b1;
            end
            if (len_ff < LEN_LAST) begin
               len_in = len_ff + 1'b1;
            end
            if (req_last_of_word || req_last_of_list) begin
               // cover test, one compare per letter
               for (int i = 0; i < lmcs_pkg::ALPHABET; i++) begin
                  if (key_ff[i] > word_in[i]) begin
                     covers = 1'b0;
                  end
               end
               if (covers && (!have_best_ff || len_in < best_len_ff)) begin
                  have_best_in = 1'b1;
                  best_num_in  = num_ff;
                  best_len_in  = len_in;
               end
               rsp_load        = 1'b1;
               out_num_in      = num_ff;
               out_len_in      = len_in;
               out_cover_in    = covers;
               out_found_in    = have_best_in;
               out_best_num_in = best_num_in;
               out_best_len_in = best_len_in;
               // word closes: reset histogram, step word number
               for (int i = 0; i < lmcs_pkg::ALPHABET; i++) begin
                  word_in[i] = '0;
               end
               len_in = '0;
               if (num_ff < NUM_LAST) begin
                  num_in = num_ff + 1'b1;
               end
               if (req_last_of_list) begin
                  num_in       = '0;
                  best_num_in  = '0;
                  best_len_in  = '0;
                  have_best_in = 1'b0;
               end
            end
         end
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   // control and histogram registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lmcs_pkg::ALPHABET; i++) begin
            key_ff[i]  <= '0;
            word_ff[i] <= '0;
         end
         len_ff       <= '0;
         num_ff       <= '0;
         best_num_ff  <= '0;
         best_len_ff  <= '0;
         have_best_ff <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         word_ff      <= word_in;
         len_ff       <= len_in;
         num_ff       <= num_in;
         best_num_ff  <= best_num_in;
         best_len_ff  <= best_len_in;
         have_best_ff <= have_best_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_num_ff      <= out_num_in;
         out_len_ff      <= out_len_in;
         out_cover_ff    <= out_cover_in;
         out_found_ff    <= out_found_in;
         out_best_num_ff <= out_best_num_in;
         out_best_len_ff <= out_best_len_in;
         out_done_ff     <= out_done_in;
      end
   end

   // result beat outputs
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_number = lmcs_pkg::OUT_NUM_W'(out_num_ff);
   assign rsp_word_length = lmcs_pkg::OUT_LEN_W'(out_len_ff);
   assign rsp_completes   = out_cover_ff;
   assign rsp_best_found  = out_found_ff;
   assign rsp_best_number = lmcs_pkg::OUT_NUM_W'(out_best_num_ff);
   assign rsp_best_length = lmcs_pkg::OUT_LEN_W'(out_best_len_ff);
   assign rsp_list_done   = out_done_ff;

endmodule

### design/lmcs_checker.sv
// lmcs_checker: port-level assertions for letter_multiset_cover_select,
// attached by bind. Depends on lmcs_pkg.
`timescale 1ns / 1ps

module lmcs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [lmcs_pkg::OUT_NUM_W-1:0]  rsp_word_number,
   input logic [lmcs_pkg::OUT_LEN_W-1:0]  rsp_word_length,
   input logic                            rsp_completes,
   input logic                            rsp_best_found,
   input logic [lmcs_pkg::OUT_NUM_W-1:0]  rsp_best_number,
   input logic [lmcs_pkg::OUT_LEN_W-1:0]  rsp_best_length,
   input logic                            rsp_list_done
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_number)
         && $stable(rsp_word_length) && $stable(rsp_completes)
         && $stable(rsp_best_found) && $stable(rsp_best_number)
         && $stable(rsp_best_length) && $stable(rsp_list_done))
      else $error("stalled result beat changed");

   // input is only held back by a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // a completing word always leaves a best no longer than itself
   a_cover_best: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_completes |-> rsp_best_found
         && rsp_best_length <= rsp_word_length && rsp_best_length != '0)
      else $error("completing word without a matching best");

   // no best means zeroed best fields
   a_no_best: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_best_found |-> rsp_best_length == '0
         && rsp_best_number == '0)
      else $error("best fields set without a best");

   // best index never lies after the current word
   a_best_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_best_found |-> rsp_best_number <= rsp_word_number)
      else $error("best word index beyond current word");

endmodule

bind letter_multiset_cover_select lmcs_checker u_lmcs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_word_number (rsp_word_number),
   .rsp_word_length (rsp_word_length),
   .rsp_completes   (rsp_completes),
   .rsp_best_found  (rsp_best_found),
   .rsp_best_number (rsp_best_number),
   .rsp_best_length (rsp_best_length),
   .rsp_list_done   (rsp_list_done)
);

### sim/lmcs_cover_checker.sv
// lmcs_cover_checker: watches the character and result channels of the letter
// multiset cover selector, predicts every word verdict and compares it.
// Depends on lmcs_pkg.
`timescale 1ns / 1ps

module lmcs_cover_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_operation,
   input  logic [lmcs_pkg::CHAR_W-1:0]     req_char_code,
   input  logic                            req_last_of_word,
   input  logic                            req_last_of_list,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [lmcs_pkg::OUT_NUM_W-1:0]  rsp_word_number,
   input  logic [lmcs_pkg::OUT_LEN_W-1:0]  rsp_word_length,
   input  logic                            rsp_completes,
   input  logic                            rsp_best_found,
   input  logic [lmcs_pkg::OUT_NUM_W-1:0]  rsp_best_number,
   input  logic [lmcs_pkg::OUT_LEN_W-1:0]  rsp_best_length,
   input  logic                            rsp_list_done,
   output int                              mismatch_count,
   output int                              verdicts_due
);

   typedef struct {
      logic [lmcs_pkg::OUT_NUM_W-1:0] word_number;
      logic [lmcs_pkg::OUT_LEN_W-1:0] word_length;
      logic                           completes;
      logic                           best_found;
      logic [lmcs_pkg::OUT_NUM_W-1:0] best_number;
      logic [lmcs_pkg::OUT_LEN_W-1:0] best_length;
      logic                           list_done;
   } word_verdict_type;

   // predicted histograms and list bookkeeping
   logic [lmcs_pkg::COUNT_W-1:0]   key_hist [lmcs_pkg::ALPHABET];
   logic [lmcs_pkg::COUNT_W-1:0]   word_hist [lmcs_pkg::ALPHABET];
   logic [lmcs_pkg::OUT_LEN_W-1:0] run_length;
   logic [lmcs_pkg::OUT_NUM_W-1:0] word_index;
   logic [lmcs_pkg::OUT_NUM_W-1:0] best_index;
   logic [lmcs_pkg::OUT_LEN_W-1:0] best_len;
   logic                           have_best;
   logic                           in_words;

   word_verdict_type pending_verdicts [$];
   int               errors = 0;

   // case-blind letter slot, -1 for anything else
   function automatic int alpha_slot(input logic [lmcs_pkg::CHAR_W-1:0] ch);
      int slot;
      slot = -1;
      if (ch >= lmcs_pkg::CHAR_UPPER_A && ch <= lmcs_pkg::CHAR_UPPER_Z)
         slot = int'(ch - lmcs_pkg::CHAR_UPPER_A);
      else if (ch >= lmcs_pkg::CHAR_LOWER_A && ch <= lmcs_pkg::CHAR_LOWER_Z)
         slot = int'(ch - lmcs_pkg::CHAR_LOWER_A);
      return slot;
   endfunction

   function automatic string verdict_text(input word_verdict_type v);
      return $sformatf("word %0d len %0d cover %0b best %0b #%0d len %0d done %0b",
                       v.word_number, v.word_length, v.completes, v.best_found,
                       v.best_number, v.best_length, v.list_done);
   endfunction

   task automatic clear_word();
      int i;
      for (i = 0; i < lmcs_pkg::ALPHABET; i++) word_hist[i] = '0;
      run_length = '0;
   endtask

   task automatic clear_list();
      word_index = '0;
      best_index = '0;
      best_len   = '0;
      have_best  = 1'b0;
   endtask

   task automatic wipe_all();
      int i;
      for (i = 0; i < lmcs_pkg::ALPHABET; i++) key_hist[i] = '0;
      clear_word();
      clear_list();
      in_words = 1'b0;
   endtask

   // one character beat into the histograms; word ends queue a verdict
   task automatic tally_char(input logic op, input logic [lmcs_pkg::CHAR_W-1:0] ch,
                             input logic end_word, input logic end_list);
      int               slot;
      int               i;
      logic             covered;
      word_verdict_type v;
      slot = alpha_slot(ch);
      if (op == lmcs_pkg::OP_KEY) begin
         // a key beat after words starts over with a fresh key
         if (in_words) wipe_all();
         if (slot >= 0 && key_hist[slot] != lmcs_pkg::COUNT_MAX) key_hist[slot]++;
      end else begin
         in_words = 1'b1;
         if (slot >= 0 && word_hist[slot] != lmcs_pkg::COUNT_MAX) word_hist[slot]++;
         if (run_length < lmcs_pkg::MAX_LENGTH_DEF) run_length++;
         if (end_word || end_list) begin
            covered = 1'b1;
            for (i = 0; i < lmcs_pkg::ALPHABET; i++)
               if (key_hist[i] > word_hist[i]) covered = 1'b0;
            // only a strictly shorter word takes over the best
            if (covered && (!have_best || run_length < best_len)) begin
               have_best  = 1'b1;
               best_index = word_index;
               best_len   = run_length;
            end
            v.word_number = word_index;
            v.word_length = run_length;
            v.completes   = covered;
            v.best_found  = have_best;
            v.best_number = best_index;
            v.best_length = best_len;
            v.list_done   = end_list;
            pending_verdicts.push_back(v);
            clear_word();
            if (word_index < lmcs_pkg::MAX_WORDS_DEF - 1) word_index++;
            if (end_list) clear_list();
         end
      end
   endtask

   task automatic check_verdict();
      word_verdict_type seen;
      word_verdict_type want;
      logic             differs;
      seen.word_number = rsp_word_number;
      seen.word_length = rsp_word_length;
      seen.completes   = rsp_completes;
      seen.best_found  = rsp_best_found;
      seen.best_number = rsp_best_number;
      seen.best_length = rsp_best_length;
      seen.list_done   = rsp_list_done;
      if (pending_verdicts.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: result beat with no word pending: %s", $time, verdict_text(seen));
      end else begin
         want = pending_verdicts.pop_front();
         differs = (seen.word_number !== want.word_number)
                || (seen.word_length !== want.word_length)
                || (seen.completes   !== want.completes)
                || (seen.best_found  !== want.best_found)
                || (seen.best_number !== want.best_number)
                || (seen.best_length !== want.best_length)
                || (seen.list_done   !== want.list_done);
         if (differs) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch\n   expected %s\n   actual   %s",
                        $time, verdict_text(want), verdict_text(seen));
         end
      end
   endtask

   // result beats go first: they come from characters taken earlier
   always @(posedge clock) begin
      if (reset) begin
         wipe_all();
         pending_verdicts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_verdict();
         if (req_valid && !req_stall)
            tally_char(req_operation, req_char_code, req_last_of_word, req_last_of_list);
      end
      mismatch_count <= errors;
      verdicts_due   <= pending_verdicts.size();
   end

endmodule

### sim/letter_multiset_cover_select_tb.sv
// letter_multiset_cover_select_tb: drives key and word character beats into
// the cover selector with bursty input and a stalling result side.
// Depends on lmcs_pkg, letter_multiset_cover_select and lmcs_cover_checker.
`timescale 1ns / 1ps

module letter_multiset_cover_select_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_BEATS   = 1300;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic                            clock;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_stall;
   logic                            req_operation    = lmcs_pkg::OP_KEY;
   logic [lmcs_pkg::CHAR_W-1:0]     req_char_code    = '0;
   logic                            req_last_of_word = 1'b0;
   logic                            req_last_of_list = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall        = 1'b0;
   logic [lmcs_pkg::OUT_NUM_W-1:0]  rsp_word_number;
   logic [lmcs_pkg::OUT_LEN_W-1:0]  rsp_word_length;
   logic                            rsp_completes;
   logic                            rsp_best_found;
   logic [lmcs_pkg::OUT_NUM_W-1:0]  rsp_best_number;
   logic [lmcs_pkg::OUT_LEN_W-1:0]  rsp_best_length;
   logic                            rsp_list_done;

   int              mismatch_count;
   int              verdicts_due;
   int              quiet_cycles = 0;
   int              beats_sent   = 0;
   int              burst_left   = 0;
   int              stall_left   = 0;
   stall_style_type stall_style  = STALL_NONE;

   letter_multiset_cover_select dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_char_code    (req_char_code),
      .req_last_of_word (req_last_of_word),
      .req_last_of_list (req_last_of_list),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_number  (rsp_word_number),
      .rsp_word_length  (rsp_word_length),
      .rsp_completes    (rsp_completes),
      .rsp_best_found   (rsp_best_found),
      .rsp_best_number  (rsp_best_number),
      .rsp_best_length  (rsp_best_length),
      .rsp_list_done    (rsp_list_done)
   );

   lmcs_cover_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_char_code    (req_char_code),
      .req_last_of_word (req_last_of_word),
      .req_last_of_list (req_last_of_list),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_number  (rsp_word_number),
      .rsp_word_length  (rsp_word_length),
      .rsp_completes    (rsp_completes),
      .rsp_best_found   (rsp_best_found),
      .rsp_best_number  (rsp_best_number),
      .rsp_best_length  (rsp_best_length),
      .rsp_list_done    (rsp_list_done),
      .mismatch_count   (mismatch_count),
      .verdicts_due     (verdicts_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side stalls in styles that are picked anew at random
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((stall_left % 5) < 2);
      endcase
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // one character beat, held until taken; bursts with random gaps between
   task automatic send_char(input logic op, input logic [lmcs_pkg::CHAR_W-1:0] ch,
                            input logic end_word, input logic end_list);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_char_code    <= ch;
      req_last_of_word <= end_word;
      req_last_of_list <= end_list;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // a whole candidate word, flagged on its last character
   task automatic send_text(input string text, input logic end_list);
      int i;
      for (i = 0; i < text.len(); i++)
         send_char(lmcs_pkg::OP_WORD, text[i], i == text.len() - 1,
                   end_list && i == text.len() - 1);
   endtask

   // mostly letters a..f in either case, sometimes any byte
   function automatic logic [lmcs_pkg::CHAR_W-1:0] pick_char();
      logic [lmcs_pkg::CHAR_W-1:0] ch;
      if ($urandom_range(0, 4) == 0)
         ch = lmcs_pkg::CHAR_W'($urandom_range(0, 255));
      else if ($urandom_range(0, 1) == 0)
         ch = lmcs_pkg::CHAR_LOWER_A + lmcs_pkg::CHAR_W'($urandom_range(0, 5));
      else
         ch = lmcs_pkg::CHAR_UPPER_A + lmcs_pkg::CHAR_W'($urandom_range(0, 5));
      return ch;
   endfunction

   // optional new key, then a well-formed list of words
   task automatic send_list();
      int n_words;
      int n_chars;
      int w;
      int c;
      logic end_word;
      logic end_list;
      if ($urandom_range(0, 1) == 0) begin
         n_chars = $urandom_range(1, 5);
         for (c = 0; c < n_chars; c++)
            send_char(lmcs_pkg::OP_KEY, pick_char(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end
      n_words = $urandom_range(1, 8);
      for (w = 0; w < n_words; w++) begin
         n_chars = $urandom_range(1, 9);
         for (c = 0; c < n_chars; c++) begin
            end_word = (c == n_chars - 1);
            end_list = end_word && (w == n_words - 1);
            // the list flag alone must also close the word
            if (end_list) end_word = 1'($urandom_range(0, 1));
            send_char(lmcs_pkg::OP_WORD, pick_char(), end_word, end_list);
         end
      end
   endtask

   // unstructured beats with every field random
   task automatic send_noise();
      int n;
      int i;
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++)
         send_char(1'($urandom_range(0, 1)), lmcs_pkg::CHAR_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int target;
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty key: any word covers it, then a key beat drops the open list
      send_char(lmcs_pkg::OP_WORD, "x", 1'b1, 1'b0);
      // key with ignored flags and the bytes just outside each letter range
      send_char(lmcs_pkg::OP_KEY, "A", 1'b1, 1'b1);
      send_char(lmcs_pkg::OP_KEY, 8'h40, 1'b0, 1'b0);
      send_char(lmcs_pkg::OP_KEY, 8'h5B, 1'b0, 1'b0);
      send_char(lmcs_pkg::OP_KEY, 8'h60, 1'b0, 1'b0);
      send_char(lmcs_pkg::OP_KEY, 8'h7B, 1'b0, 1'b0);
      send_char(lmcs_pkg::OP_KEY, 8'hFF, 1'b0, 1'b0);
      send_char(lmcs_pkg::OP_KEY, 8'h00, 1'b0, 1'b0);
      send_char(lmcs_pkg::OP_KEY, "z", 1'b0, 1'b0);
      send_char(lmcs_pkg::OP_KEY, 8'h80, 1'b0, 1'b0);
      // first completing word, a tie that keeps it, a miss
      send_text("Za", 1'b0);
      send_text("aZ", 1'b0);
      send_text("b!", 1'b0);
      // list flag alone closes word and list
      send_char(lmcs_pkg::OP_WORD, "a", 1'b0, 1'b1);
      // same key, fresh list
      send_text("zAq", 1'b1);
      // key after a closed list, then key in the middle of a list
      send_char(lmcs_pkg::OP_KEY, "y", 1'b1, 1'b1);
      send_text("Y", 1'b0);
      send_char(lmcs_pkg::OP_KEY, "m", 1'b0, 1'b0);
      send_text("MM", 1'b1);

      // key and word letter counts and word length run into their ceilings
      for (i = 0; i < 256; i++)
         send_char(lmcs_pkg::OP_KEY,
                   ($urandom_range(0, 1) == 0) ? lmcs_pkg::CHAR_LOWER_A
                                               : lmcs_pkg::CHAR_UPPER_A,
                   1'b0, 1'b0);
      for (i = 0; i < 258; i++)
         send_char(lmcs_pkg::OP_WORD, lmcs_pkg::CHAR_LOWER_A, i == 257, 1'b0);
      for (i = 0; i < 256; i++)
         send_char(lmcs_pkg::OP_WORD, lmcs_pkg::CHAR_UPPER_A, 1'b0, i == 255);

      // one list long enough to pin the word number at its top
      send_char(lmcs_pkg::OP_KEY, "c", 1'b0, 1'b0);
      for (i = 0; i < lmcs_pkg::MAX_WORDS_DEF + 6; i++)
         send_char(lmcs_pkg::OP_WORD,
                   lmcs_pkg::CHAR_LOWER_A + lmcs_pkg::CHAR_W'($urandom_range(0, 3)),
                   1'b1, i == lmcs_pkg::MAX_WORDS_DEF + 5);

      // random lists with some noise mixed in
      target = beats_sent + RANDOM_BEATS;
      while (beats_sent < target) begin
         if ($urandom_range(0, 9) < 7)
            send_list();
         else
            send_noise();
      end

      // drain the result side, then a short tail
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_due != 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && verdicts_due == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
